// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

   // Input request: one optional message byte and an end marker
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   // Result: one digest word, word 0 first
   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_type;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned BLOCK_W     = BLOCK_BYTES * 8;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned CHAIN_WORDS = 8;

   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] LENGTH_OFFSET = 6'd56;

   localparam logic [31:0] INITIAL_H [CHAIN_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher_unit.sv =====
// SHA-256 over a byte stream. Each request carries at most one message byte
// and may close the message. After a request that neither completes a 64-byte
// block nor closes the message the block is ready again. The request that
// completes a block is followed by a busy time: the 64 rounds through the
// single round unit, then a fold of the working words into the chaining words.
// After a closing request the block inserts padding and the length at one byte
// per cycle outside the compressions (9 to 72 bytes) and runs one or two more
// compressions, then presents the eight digest words one per cycle as the
// receiver takes them, and returns to its initial state. req_ready is low for all of that time.
module sha256_stream_hasher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   localparam int unsigned W0_HI  = sha_pkg::BLOCK_W - 1;
   localparam int unsigned W1_HI  = sha_pkg::BLOCK_W - 1 - sha_pkg::WORD_W;
   localparam int unsigned W9_HI  = sha_pkg::BLOCK_W - 1 - 9 * sha_pkg::WORD_W;
   localparam int unsigned W14_HI = sha_pkg::BLOCK_W - 1 - 14 * sha_pkg::WORD_W;

   state_type   state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  word_idx_ff, word_idx_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic        ending_ff, ending_in;
   logic        mark_ff, mark_in;
   logic        len_ff, len_in;
   logic [sha_pkg::BLOCK_W-1:0] sched_ff, sched_in;
   logic [7:0][31:0] work_ff, work_in;
   logic [7:0][31:0] chain_ff, chain_in;

   logic        put_en;
   logic [7:0]  put_data;
   logic [63:0] len_bits;
   logic [7:0]  len_byte;
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2, ch, maj;
   logic        req_acc, rsp_acc;

   // Schedule window taps: the current word sits at the top of the window
   assign w0  = sched_ff[W0_HI  -: 32];
   assign w1  = sched_ff[W1_HI  -: 32];
   assign w9  = sched_ff[W9_HI  -: 32];
   assign w14 = sched_ff[W14_HI -: 32];
   assign w_new = sha_pkg::small_sigma1(w14) + w9 + sha_pkg::small_sigma0(w1) + w0;

   // Round unit
   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
              ^ (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + sha_pkg::big_sigma1(work_ff[4]) + ch
              + sha_pkg::ROUND_K[round_ff] + w0;
   assign t2  = sha_pkg::big_sigma0(work_ff[0]) + maj;

   // Length bytes, most significant first, at block offsets 56..63
   assign len_bits = {count_ff, 3'b000};
   assign len_byte = len_bits[{~fill_ff[2:0], 3'b111} -: 8];

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign rsp_data.digest_word = chain_ff[word_idx_ff];
   assign rsp_data.last_word   = (word_idx_ff == 3'd7);

   // Pick the byte to append: message byte when idle, padding in the padding state
   always_comb begin
      put_en   = 1'b0;
      put_data = req_data.msg_byte;
      mark_in  = mark_ff;
      len_in   = len_ff;
      if (req_acc) begin
         put_en = req_data.byte_present;
      end else if (state_ff == ST_PAD) begin
         put_en = 1'b1;
         priority if (!mark_ff) begin
            put_data = sha_pkg::PAD_MARK;
            mark_in  = 1'b1;
         end else if (len_ff || fill_ff == sha_pkg::LENGTH_OFFSET) begin
            put_data = len_byte;
            len_in   = 1'b1;
         end else begin
            put_data = 8'h00;
         end
      end
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in    = state_ff;
      round_in    = round_ff;
      word_idx_in = word_idx_ff;
      fill_in     = fill_ff;
      count_in    = count_ff;
      ending_in   = ending_ff;
      sched_in    = sched_ff;
      work_in     = work_ff;
      chain_in    = chain_ff;

      // Shift an appended byte into the block window
      if (put_en) begin
         sched_in = {sched_ff[sha_pkg::BLOCK_W-9:0], put_data};
         fill_in  = fill_ff + 6'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.byte_present) begin
                  count_in = count_ff + 61'd1;
               end
               ending_in = req_data.end_of_message;
               priority if (req_data.byte_present && fill_ff == 6'd63) begin
                  state_in = ST_ROUND;
                  work_in  = chain_ff;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == 6'd63) begin
               state_in = ST_ROUND;
               work_in  = chain_ff;
            end
         end
         ST_ROUND: begin
            work_in[0] = t1 + t2;
            work_in[1] = work_ff[0];
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3] + t1;
            work_in[5] = work_ff[4];
            work_in[6] = work_ff[5];
            work_in[7] = work_ff[6];
            sched_in   = {sched_ff[sha_pkg::BLOCK_W-33:0], w_new};
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            priority if (len_ff) begin
               state_in = ST_OUT;
            end else if (ending_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               word_idx_in = word_idx_ff + 3'd1;
               if (word_idx_ff == 3'd7) begin
                  state_in  = ST_IDLE;
                  fill_in   = 6'd0;
                  count_in  = 61'd0;
                  ending_in = 1'b0;
                  for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++) begin
                     chain_in[i] = sha_pkg::INITIAL_H[i];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         round_ff    <= 6'd0;
         word_idx_ff <= 3'd0;
         fill_ff     <= 6'd0;
         count_ff    <= 61'd0;
         ending_ff   <= 1'b0;
         mark_ff     <= 1'b0;
         len_ff      <= 1'b0;
         for (int i = 0; i < sha_pkg::CHAIN_WORDS; i++) begin
            chain_ff[i] <= sha_pkg::INITIAL_H[i];
         end
      end else begin
         state_ff    <= state_in;
         round_ff    <= round_in;
         word_idx_ff <= word_idx_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         ending_ff   <= ending_in;
         chain_ff    <= chain_in;
         if (rsp_acc && word_idx_ff == 3'd7) begin
            mark_ff <= 1'b0;
            len_ff  <= 1'b0;
         end else begin
            mark_ff <= mark_in;
            len_ff  <= len_in;
         end
      end
   end

   // Block window and working words
   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      work_ff  <= work_in;
   end

   // Never take a request while a digest word is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while digest pending");

   // The last round always hands over to the fold cycle
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd63) |=> (state_ff == ST_ADD))
      else $error("round sequence did not end in fold");

   // Padding runs only for a closed message, unless the block is empty and no mark is placed
   a_pad_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> ending_ff || (fill_ff == 6'd0 && !mark_ff))
      else $error("padding without end of message");

   // After the last digest word the hasher is back at its initial state
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_data.last_word) |=>
         (fill_ff == 6'd0 && count_ff == 61'd0 && !len_ff
          && chain_ff[0] == sha_pkg::INITIAL_H[0]))
      else $error("hasher not restarted after digest");

endmodule

// ===== tb/tb_sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_unit;

   localparam int unsigned CLOCK_HALF    = 4;
   localparam int unsigned RESET_CYCLES  = 9;
   localparam int unsigned RANDOM_ITEMS  = 260;
   localparam int unsigned DRAIN_CYCLES  = 300;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned DIGEST_WORDS  = 8;
   localparam int unsigned BLOCK_SIZE    = 64;
   localparam int unsigned LENGTH_POS    = 56;
   localparam logic [7:0]  PAD_BYTE      = 8'h80;

   localparam logic [31:0] START_CHAIN [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sha_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sha_pkg::rsp_type rsp_data;

   sha_pkg::req_type pending_requests [$];
   sha_pkg::rsp_type expected_digest [$];
   int unsigned      counted_items;
   int unsigned      total_requests;
   int unsigned      accepted_requests;
   int unsigned      failures;
   int unsigned      req_gap;
   int unsigned      req_quiet;
   int unsigned      rsp_stall;
   int unsigned      rsp_quiet;
   int unsigned      idle_cycles;

   // Hash state of the predictor
   logic [31:0] chain_h [DIGEST_WORDS];
   logic [7:0]  block_bytes [BLOCK_SIZE];
   int unsigned fill_level;
   logic [60:0] message_len;

   sha256_stream_hasher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] sum0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] sum1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] mix0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] mix1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < DIGEST_WORDS; i++) chain_h[i] = START_CHAIN[i];
      fill_level  = 0;
      message_len = '0;
   endfunction

   // Run the 64 rounds over the collected block and fold into the chain
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] v [DIGEST_WORDS];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i-16] + mix0(w[i-15]) + w[i-7] + mix1(w[i-2]);
      end
      for (int i = 0; i < DIGEST_WORDS; i++) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
         t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < DIGEST_WORDS; i++) chain_h[i] = chain_h[i] + v[i];
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      block_bytes[fill_level] = b;
      fill_level++;
      if (fill_level == BLOCK_SIZE) begin
         compress_block();
         fill_level = 0;
      end
   endfunction

   // Predict the digest words caused by one accepted request
   function automatic void predict_digest(input sha_pkg::req_type r);
      logic [63:0]      bit_len;
      sha_pkg::rsp_type word;
      if (r.byte_present) begin
         absorb_byte(r.msg_byte);
         message_len = message_len + 61'd1;
      end
      if (!r.end_of_message) return;
      bit_len = {message_len, 3'b000};
      absorb_byte(PAD_BYTE);
      while (fill_level != LENGTH_POS) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         word.digest_word = chain_h[i];
         word.last_word   = (i == DIGEST_WORDS - 1);
         expected_digest.push_back(word);
      end
      restart_hash();
   endfunction

   function automatic void queue_request(input logic [7:0] b, input logic present,
                                         input logic closing);
      sha_pkg::req_type r;
      r.msg_byte       = b;
      r.byte_present   = present;
      r.end_of_message = closing;
      pending_requests.push_back(r);
      if (present || closing) counted_items++;
   endfunction

   // Queue one message; the end comes on the last byte or as a request of its own
   function automatic void queue_message(input int unsigned len);
      bit          joined;
      int unsigned style;
      logic [7:0]  b;
      joined = (len != 0) && ($urandom_range(0, 1) == 1);
      style  = $urandom_range(0, 9);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         case (style)
            0: b = 8'h00;
            1: b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         queue_request(b, 1'b1, joined && (i == len - 1));
      end
      if (!joined) queue_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endfunction

   // Mostly short messages, some around the padding and block edges, a few long
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 20);
      if (r < 80) begin
         if ($urandom_range(0, 1) == 1) return $urandom_range(54, 57);
         return $urandom_range(62, 65);
      end
      return $urandom_range(21, 130);
   endfunction

   // Mostly short gaps, a few long ones, and quiet stretches with none
   function automatic int unsigned pick_gap(inout int unsigned quiet_left);
      int unsigned r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) quiet_left = $urandom_range(20, 60);
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // Drive requests from the pending queue and predict on acceptance
   always @(posedge clock) begin : request_driver
      bit sending;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sending = req_valid;
         if (req_valid && req_ready) begin
            predict_digest(req_data);
            accepted_requests++;
            sending = 1'b0;
         end
         if (!sending) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_requests.size() != 0) begin
               req_data <= pending_requests.pop_front();
               sending   = 1'b1;
               req_gap   = pick_gap(req_quiet);
            end
         end
         req_valid <= sending;
      end
   end

   // Check each accepted digest word and stall the result side at random
   always @(posedge clock) begin : digest_monitor
      sha_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digest.size() == 0) begin
               $error("digest_word: expected none, actual %h", rsp_data.digest_word);
               failures++;
            end else begin
               want = expected_digest.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_data.digest_word);
                  failures++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %b, actual %b", want.last_word, rsp_data.last_word);
                  failures++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap(rsp_quiet);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned random_goal;
      restart_hash();

      // Empty message, with a byte on the bus that must be ignored
      queue_request(8'ha5, 1'b0, 1'b1);
      // Ignored request between messages
      queue_request(8'hff, 1'b0, 1'b0);
      // "abc" with the end on the last byte
      queue_request(8'h61, 1'b1, 1'b0);
      queue_request(8'h62, 1'b1, 1'b0);
      queue_request(8'h63, 1'b1, 1'b1);
      // Single 0xff byte, then a separate end request
      queue_request(8'hff, 1'b1, 1'b0);
      queue_request(8'h00, 1'b0, 1'b1);
      // Single zero byte with the end together
      queue_request(8'h00, 1'b1, 1'b1);
      // Ignored request, then an empty message
      queue_request(8'h00, 1'b0, 1'b0);
      queue_request(8'hff, 1'b0, 1'b1);

      random_goal = counted_items + RANDOM_ITEMS;
      while (counted_items < random_goal) queue_message(pick_length());
      total_requests = pending_requests.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_requests != total_requests || expected_digest.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/sha_pkg.sv
hw/rtl/sha256_stream_hasher_unit.sv
tb/tb_sha256_stream_hasher_unit.sv
